// ----- src/lcgr_pkg.sv -----
// Shared constants and types for the ranged LCG random number block.
package lcgr_pkg;

	localparam int WORD_W = 32;
	localparam logic [WORD_W-1:0] LCG_MULT = 32'd3039177861;
	localparam logic [WORD_W-1:0] LCG_INC = 32'd1;
	localparam int LCG_STEPS = 16;
	localparam int TOP_SHIFT = 30;
	localparam int STEP_CNT_W = $clog2(LCG_STEPS);
	localparam int DIV_CNT_W = $clog2(WORD_W);
	localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_GEN  = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

endpackage

// ----- src/lcgr_mod.sv -----
// Bit-serial restoring remainder unit: one quotient bit per cycle.
module lcgr_mod (
	input  logic                clk,
	input  logic                arst_n,
	input  lcgr_pkg::div_req_t  req,
	output logic                done,
	output lcgr_pkg::word_t     remainder
);

	logic                              busy_q;
	logic                              done_q;
	logic [lcgr_pkg::DIV_CNT_W-1:0]    cnt_q;
	lcgr_pkg::word_t                   rem_q;
	lcgr_pkg::word_t                   dq_q;
	lcgr_pkg::word_t                   div_q;
	logic [lcgr_pkg::WORD_W:0]         trial;
	logic [lcgr_pkg::WORD_W:0]         diff;

	// The partial remainder stays below the divisor, so the trial value
	// stays below twice the divisor and fits one extra bit.
	assign trial = {rem_q, dq_q[lcgr_pkg::WORD_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= lcgr_pkg::DIV_CNT_W'(lcgr_pkg::WORD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			dq_q <= {dq_q[lcgr_pkg::WORD_W-2:0], 1'b0};
			if (!diff[lcgr_pkg::WORD_W]) begin
				rem_q <= diff[lcgr_pkg::WORD_W-1:0];
			end else begin
				rem_q <= trial[lcgr_pkg::WORD_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- src/lcg_top_bits_random_range.sv -----
// Ranged random number block: serial LCG word draw followed by a serial remainder.
//
// Input channel (in_valid/in_ready) carries func, range_low and range_high;
// output channel (out_valid/out_ready) carries value and range_error.
// cfg_we with cfg_wdata writes the seed and loads it into the generator state;
// write it only while the block is idle.
// One transaction is worked on at a time. The generator takes one LCG step per
// cycle on its single multiplier, and two bits enter the word shift register
// each cycle. In raw mode, and for an empty or inverted range, the drawn word
// (or zero) goes from the generator state through the finish state to the
// output register. In range mode the remainder unit then works on the word,
// one bit per cycle, and its remainder plus range_low is registered before the
// finish state. The next input transaction is taken the cycle after the
// result has been moved to the output register.
// At reset the generator state is 1 and no result is pending.
// When the receiver stalls, the result waits in the output register; a further
// finished result waits inside the block until the output register is free,
// and no new input is taken meanwhile.
module lcg_top_bits_random_range (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic        range_error
);

	lcgr_pkg::state_t                  state_q;
	lcgr_pkg::word_t                   gen_state_q;
	lcgr_pkg::word_t                   word_q;
	logic [lcgr_pkg::STEP_CNT_W-1:0]   gen_cnt_q;
	logic                              func_q;
	logic                              err_q;
	lcgr_pkg::word_t                   span_q;
	lcgr_pkg::word_t                   low_q;
	lcgr_pkg::word_t                   res_q;
	logic                              res_err_q;
	logic                              out_valid_q;
	lcgr_pkg::word_t                   value_q;
	logic                              range_error_q;

	lcgr_pkg::word_t                   nxt_state;
	lcgr_pkg::word_t                   nxt_word;
	logic [lcgr_pkg::WORD_W:0]         span_ext;
	logic                              in_take;
	logic                              gen_last;
	logic                              out_free;
	lcgr_pkg::div_req_t                div_req;
	logic                              div_done;
	lcgr_pkg::word_t                   div_rem;

	assign in_ready  = (state_q == lcgr_pkg::S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign nxt_state = gen_state_q * lcgr_pkg::LCG_MULT + lcgr_pkg::LCG_INC;
	assign nxt_word  = {word_q[lcgr_pkg::WORD_W-3:0], 2'(nxt_state >> lcgr_pkg::TOP_SHIFT)};
	assign span_ext  = {1'b0, range_high} - {1'b0, range_low};
	assign gen_last  = (state_q == lcgr_pkg::S_GEN)
		&& (gen_cnt_q == lcgr_pkg::STEP_CNT_W'(lcgr_pkg::LCG_STEPS - 1));
	assign out_free  = !out_valid_q || out_ready;

	assign div_req.start    = gen_last && func_q && !err_q;
	assign div_req.dividend = nxt_word;
	assign div_req.divisor  = span_q;

	lcgr_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcgr_pkg::S_IDLE;
			gen_state_q <= lcgr_pkg::SEED_RESET;
			gen_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == lcgr_pkg::S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				gen_state_q <= cfg_wdata;
			end else if (state_q == lcgr_pkg::S_GEN) begin
				gen_state_q <= nxt_state;
			end
			case (state_q)
				lcgr_pkg::S_IDLE: begin
					gen_cnt_q <= '0;
					if (in_take) begin
						state_q <= lcgr_pkg::S_GEN;
					end
				end
				lcgr_pkg::S_GEN: begin
					gen_cnt_q <= gen_cnt_q + 1'b1;
					if (gen_last) begin
						if (func_q && !err_q) begin
							state_q <= lcgr_pkg::S_DIV;
						end else begin
							state_q <= lcgr_pkg::S_FIN;
						end
					end
				end
				lcgr_pkg::S_DIV: begin
					if (div_done) begin
						state_q <= lcgr_pkg::S_FIN;
					end
				end
				lcgr_pkg::S_FIN: begin
					if (out_free) begin
						state_q <= lcgr_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= lcgr_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q <= func;
			// An empty range shows as a borrow or a zero span.
			err_q  <= span_ext[lcgr_pkg::WORD_W] || (span_ext[lcgr_pkg::WORD_W-1:0] == '0);
			span_q <= span_ext[lcgr_pkg::WORD_W-1:0];
			low_q  <= range_low;
			word_q <= '0;
		end else if (state_q == lcgr_pkg::S_GEN) begin
			word_q <= nxt_word;
		end
		if (gen_last) begin
			res_err_q <= func_q && err_q;
			if (!func_q) begin
				res_q <= nxt_word;
			end else begin
				res_q <= '0;
			end
		end else if ((state_q == lcgr_pkg::S_DIV) && div_done) begin
			res_q <= div_rem + low_q;
		end
		if ((state_q == lcgr_pkg::S_FIN) && out_free) begin
			value_q       <= res_q;
			range_error_q <= res_err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign range_error = range_error_q;

`ifndef NO_ASSERTIONS
	a_take_starts_gen: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == lcgr_pkg::S_GEN))
		else $error("accepted transaction did not start the generator");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == lcgr_pkg::S_DIV))
		else $error("remainder finished outside the remainder phase");

	a_gen_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		gen_last |=> (state_q != lcgr_pkg::S_GEN))
		else $error("generator ran past its sixteen steps");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (value == '0))
		else $error("range error result carries a non-zero value");
`endif

endmodule
